>>> rtl/keyed_latency_statistics_table_macros.svh
// assertion macros used by the top-level rtl file
`ifndef KEYED_LATENCY_STATISTICS_TABLE_MACROS_SVH
`define KEYED_LATENCY_STATISTICS_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KLST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("klst check failed");

// next-cycle implication, checked out of reset
`define KLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("klst check failed");

`endif

>>> rtl/klst_pkg.sv
// types and constants of the keyed latency statistics table
`default_nettype none

package klst_pkg;

    localparam logic [31:0] U32_ALL = 32'hFFFF_FFFF;
    localparam logic [63:0] U64_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_LOG   = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key;
        logic [31:0] amount;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] min_value;
        logic [31:0] max_value;
        logic [31:0] average;
        logic [31:0] total_count;
    } t_result;

    typedef struct packed {
        logic [31:0] min_v;
        logic [31:0] max_v;
        logic [63:0] sum;
        logic [31:0] count;
    } t_stats;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/keyed_latency_statistics_table.sv
// top level: keyed statistics table with serial key search and serial divider
//
//  channel   direction  handshake             payload
//  command   in         start & !busy         i_item   (mode, key, amount)
//  result    out        o_done, one cycle     o_result (status .. total_count)
//
// from accept to the next accept an item passes these steps in order:
// the key search reads one entry per cycle until a hit or the last entry,
// then a stats read, an update, the bit-serial divider when the count is
// nonzero, a result state and an idle state; without a divide (miss, full,
// zero count) the divider step drops out.
// reset is synchronous, active low, clears all valid bits; results cannot stall.
`default_nettype none

`include "keyed_latency_statistics_table_macros.svh"

module keyed_latency_statistics_table #(
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire klst_pkg::t_item   i_item,
    output logic                   busy,
    output logic                   o_done,
    output klst_pkg::t_result      o_result
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_ENTRIES - 1);

    klst_pkg::t_state r_state, n_state;

    logic [NUM_ENTRIES-1:0] r_valid;
    logic [63:0]            r_key_mem [NUM_ENTRIES];
    klst_pkg::t_stats       r_st_mem  [NUM_ENTRIES];

    klst_pkg::t_item   r_item;
    logic [IW-1:0]     r_idx;
    logic              r_issue;
    logic              r_pv;
    logic [IW-1:0]     r_pidx;
    logic [63:0]       r_key_q;
    logic              r_free_found;
    logic [IW-1:0]     r_free_idx;
    logic [IW-1:0]     r_slot;
    logic              r_found;
    logic              r_alloc;
    klst_pkg::t_stats  r_st_q;
    klst_pkg::t_result r_result;

    klst_pkg::t_div_req div_req;
    klst_pkg::t_div_rsp div_rsp;

    logic accept;
    logic is_write;
    logic hit_now, free_now, last_now, scan_end, any_free;
    logic key_we, st_we;
    logic exists;
    logic go_div;
    klst_pkg::t_stats base, n_stats;
    logic [64:0] sum_ext;
    logic [32:0] cnt_ext;

    assign accept   = start && !busy;
    assign is_write = (r_item.mode == klst_pkg::MODE_LOG) || (r_item.mode == klst_pkg::MODE_ADD);

    // search pipeline: data for r_pidx arrives in the cycle after its address
    assign hit_now  = r_pv && r_valid[r_pidx] && (r_key_q == r_item.key);
    assign free_now = r_pv && !r_valid[r_pidx];
    assign last_now = r_pv && (r_pidx == LAST);
    assign scan_end = hit_now || last_now;
    assign any_free = r_free_found || free_now;

    assign exists = r_found || r_alloc;

    // new entry starts from min all ones and zero max, sum and count
    always_comb begin
        if (r_alloc) begin
            base.min_v = klst_pkg::U32_ALL;
            base.max_v = '0;
            base.sum   = '0;
            base.count = '0;
        end else begin
            base = r_st_q;
        end
        sum_ext = {1'b0, base.sum} + {33'd0, r_item.amount};
        cnt_ext = {1'b0, base.count} + {1'b0, r_item.amount};
        n_stats = base;
        case (r_item.mode)
            klst_pkg::MODE_LOG: begin
                if (r_item.amount < base.min_v) n_stats.min_v = r_item.amount;
                if (r_item.amount > base.max_v) n_stats.max_v = r_item.amount;
                n_stats.sum = sum_ext[64] ? klst_pkg::U64_ALL : sum_ext[63:0];
                if (base.count != klst_pkg::U32_ALL) n_stats.count = base.count + 32'd1;
            end
            klst_pkg::MODE_ADD: begin
                n_stats.count = cnt_ext[32] ? klst_pkg::U32_ALL : cnt_ext[31:0];
            end
            default: begin
                n_stats = base;
            end
        endcase
    end

    assign go_div = exists && (n_stats.count != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            klst_pkg::ST_IDLE:   if (accept) n_state = klst_pkg::ST_SCAN;
            klst_pkg::ST_SCAN:   if (scan_end) n_state = klst_pkg::ST_READ;
            klst_pkg::ST_READ:   n_state = klst_pkg::ST_UPDATE;
            klst_pkg::ST_UPDATE: n_state = go_div ? klst_pkg::ST_DIV : klst_pkg::ST_OUT;
            klst_pkg::ST_DIV:    if (div_rsp.done) n_state = klst_pkg::ST_OUT;
            klst_pkg::ST_OUT:    n_state = klst_pkg::ST_IDLE;
            default:             n_state = klst_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy             = 1'b1;
        o_done           = 1'b0;
        key_we           = 1'b0;
        st_we            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = n_stats.sum;
        div_req.divisor  = n_stats.count;
        case (r_state)
            klst_pkg::ST_IDLE: busy = 1'b0;
            klst_pkg::ST_UPDATE: begin
                key_we        = r_alloc;
                st_we         = exists && is_write;
                div_req.start = go_div;
            end
            klst_pkg::ST_OUT: o_done = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    klst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= klst_pkg::ST_IDLE;
            r_valid <= '0;
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (key_we) r_valid[r_slot] <= 1'b1;
            if (accept) begin
                r_issue <= 1'b1;
                r_pv    <= 1'b0;
            end else if (r_state == klst_pkg::ST_SCAN) begin
                r_pv <= r_issue && !scan_end;
                if (r_issue && r_idx == LAST) r_issue <= 1'b0;
            end else begin
                r_issue <= 1'b0;
                r_pv    <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (key_we) r_key_mem[r_slot] <= r_item.key;
        r_key_q <= r_key_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) r_st_mem[r_slot] <= n_stats;
        r_st_q <= r_st_mem[r_slot];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item       <= i_item;
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_found      <= 1'b0;
            r_alloc      <= 1'b0;
        end else begin
            case (r_state)
                klst_pkg::ST_SCAN: begin
                    r_pidx <= r_idx;
                    if (r_issue && r_idx != LAST) r_idx <= r_idx + 1'b1;
                    if (free_now && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_pidx;
                    end
                    if (scan_end) begin
                        r_found <= hit_now;
                        r_alloc <= !hit_now && is_write && any_free;
                        if (hit_now || !r_free_found) r_slot <= r_pidx;
                        else r_slot <= r_free_idx;
                    end
                end
                klst_pkg::ST_UPDATE: begin
                    if (exists) begin
                        r_result.status      <= klst_pkg::STATUS_OK;
                        r_result.slot        <= 4'(r_slot);
                        r_result.min_value   <= n_stats.min_v;
                        r_result.max_value   <= n_stats.max_v;
                        r_result.total_count <= n_stats.count;
                    end else begin
                        r_result.status      <= is_write ? klst_pkg::STATUS_FULL
                                                         : klst_pkg::STATUS_MISS;
                        r_result.slot        <= '0;
                        r_result.min_value   <= klst_pkg::U32_ALL;
                        r_result.max_value   <= '0;
                        r_result.total_count <= '0;
                    end
                    r_result.average <= '0;
                end
                klst_pkg::ST_DIV: begin
                    if (div_rsp.done) r_result.average <= div_rsp.quotient;
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    assign o_result = r_result;

    `KLST_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `KLST_ASSERT_NEXT(a_done_then_idle, i_clk, i_rst_n, o_done, !busy)
    `KLST_ASSERT_NOW(a_div_in_state, i_clk, i_rst_n, div_rsp.done, r_state == klst_pkg::ST_DIV)
    `KLST_ASSERT_NOW(a_hit_no_alloc, i_clk, i_rst_n, r_state == klst_pkg::ST_UPDATE, !(r_found && r_alloc))
    `KLST_ASSERT_NEXT(a_alloc_sets_valid, i_clk, i_rst_n, key_we, r_valid[$past(r_slot)])

endmodule

`default_nettype wire

>>> rtl/klst_div.sv
// bit-serial restoring divider, 64-bit sum by 32-bit count, saturated quotient
`default_nettype none

module klst_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire klst_pkg::t_div_req  i_req,
    output klst_pkg::t_div_rsp       o_rsp
);

    logic                           r_run;
    logic                           r_done;
    logic [klst_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [63:0]                    r_dvd;
    logic [31:0]                    r_rem;
    logic [31:0]                    r_dsr;

    logic [32:0] rem_sh;
    logic [33:0] diff;
    logic        ge;

    // one quotient bit per cycle, quotient shifts into the dividend register
    assign rem_sh = {r_rem, r_dvd[63]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
    assign ge     = !diff[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == klst_pkg::DIV_CNT_W'(klst_pkg::DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_run) begin
            r_dvd <= {r_dvd[62:0], ge};
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
        end
    end

    assign o_rsp = {r_done, ((|r_dvd[63:32]) ? klst_pkg::U32_ALL : r_dvd[31:0])};

endmodule

`default_nettype wire
